// File: rtl/sme_pkg.sv
package sme_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int WORD_W      = 32;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(WORD_W);
    localparam int ACT_W       = 4;
    localparam int STATUS_W    = 3;

    typedef enum logic [ACT_W-1:0] {
        OP_PUSH  = 4'd0,
        OP_POP   = 4'd1,
        OP_DUP   = 4'd2,
        OP_SWAP  = 4'd3,
        OP_ADD   = 4'd4,
        OP_SUB   = 4'd5,
        OP_MUL   = 4'd6,
        OP_DIV   = 4'd7,
        OP_PRINT = 4'd8
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_UNKNOWN   = 3'd4,
        ST_HALTED    = 3'd5
    } status_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: rtl/sme_ram.sv
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr0,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr1,
    output logic [WIDTH-1:0]                           rdata0,
    output logic [WIDTH-1:0]                           rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata0 <= mem[raddr0];
            rdata1 <= mem[raddr1];
        end
    end

endmodule

// File: rtl/sme_div.sv
module sme_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  sme_pkg::div_req_t  req,
    output sme_pkg::div_rsp_t  rsp
);

    localparam int W = sme_pkg::WORD_W;

    logic                          busy_reg;
    logic                          done_reg;
    logic                          neg_reg;
    logic [sme_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [W:0]                    rem_reg;
    logic [W-1:0]                  quo_reg;
    logic [W-1:0]                  den_reg;

    logic [W:0]   shifted;
    logic [W:0]   trial;
    logic [W-1:0] num_abs;
    logic [W-1:0] den_abs;

    assign num_abs = req.num[W-1] ? (W'(0) - req.num) : req.num;
    assign den_abs = req.den[W-1] ? (W'(0) - req.den) : req.den;
    assign shifted = {rem_reg[W-1:0], quo_reg[W-1]};
    assign trial   = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // One quotient bit per cycle, restoring form on the magnitudes.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            neg_reg <= req.num[W-1] ^ req.den[W-1];
            quo_reg <= num_abs;
            den_reg <= den_abs;
            rem_reg <= '0;
            cnt_reg <= sme_pkg::DIV_CNT_W'(W - 1);
        end else if (busy_reg) begin
            if (!trial[W]) begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - sme_pkg::DIV_CNT_W'(1);
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

endmodule

// File: rtl/stack_machine_executor_top.sv
// Stack machine executor. Each word on the s_ channel is one instruction
// (opcode and immediate); each instruction gives exactly one word on the
// m_ channel with its status, the printed value and the stack depth after it.
// The stack sits in a dual-read synchronous RAM. An instruction is taken in
// the idle cycle, its two top entries are read out of the RAM, and in the
// next cycle the result is computed, written back and handed to the output
// register. Push, pop, dup, add, sub and print finish in that execute cycle;
// swap and mul take a second write-back state, and div waits for the
// one-bit-per-cycle divider. An instruction is accepted while the
// previous result still waits in the output register; if the receiver
// stalls longer, the next result is parked in a hold register and no new
// word is taken until it has moved out. After an error the machine answers
// every word with the halted status until reset. Reset empties the stack
// and clears the halted condition; the RAM contents are not cleared, as
// entries at or above the stack depth are never used.
module stack_machine_executor_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] action, [35:4] immediate, [39:36] zero
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] status, [3] printed, [35:4] print_value, [46:36] depth, [47] zero
    output logic [47:0] m_tdata
);

    localparam int W  = sme_pkg::WORD_W;
    localparam int AW = sme_pkg::ADDR_W;
    localparam int CW = sme_pkg::CNT_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_SWAP2 = 6'b000100,
        S_MULW  = 6'b001000,
        S_DIVW  = 6'b010000,
        S_HOLD  = 6'b100000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic                      halted_reg, halted_next;
    logic [sme_pkg::ACT_W-1:0] act_reg;
    logic [W-1:0]              imm_reg;
    logic [W-1:0]              opa_reg, opa_next;
    logic [W-1:0]              prod_reg, prod_next;

    logic                      m_tvalid_reg;
    sme_pkg::status_t          m_status_reg;
    logic                      m_printed_reg;
    logic [W-1:0]              m_pval_reg;
    logic [CW-1:0]             m_depth_reg;

    sme_pkg::status_t          hold_status_reg;
    logic                      hold_printed_reg;
    logic [W-1:0]              hold_pval_reg;
    logic [CW-1:0]             hold_depth_reg;

    logic                      accept;
    logic                      out_free;
    logic                      fin;
    sme_pkg::status_t          fin_status;
    logic                      fin_printed;
    logic [W-1:0]              fin_pval;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [W-1:0]              ram_wdata;
    logic [W-1:0]              rd_top;
    logic [W-1:0]              rd_sec;
    logic [W-1:0]              full_prod;

    logic [CW-1:0]             cnt_m1;
    logic [CW-1:0]             cnt_m2;
    logic [CW-1:0]             cnt_p1;
    logic                      n_empty;
    logic                      n_lt2;
    logic                      n_full;

    sme_pkg::div_req_t         div_req;
    sme_pkg::div_rsp_t         div_rsp;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign cnt_m1  = count_reg - CW'(1);
    assign cnt_m2  = count_reg - CW'(2);
    assign cnt_p1  = count_reg + CW'(1);
    assign n_empty = (count_reg == '0);
    assign n_lt2   = (count_reg < CW'(2));
    assign n_full  = (count_reg >= CW'(sme_pkg::STACK_DEPTH));

    assign full_prod = rd_sec * rd_top;

    sme_ram #(
        .WIDTH (W),
        .DEPTH (sme_pkg::STACK_DEPTH)
    ) u_stack (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .re     (accept),
        .raddr0 (cnt_m1[AW-1:0]),
        .raddr1 (cnt_m2[AW-1:0]),
        .rdata0 (rd_top),
        .rdata1 (rd_sec)
    );

    sme_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        halted_next   = halted_reg;
        opa_next      = opa_reg;
        prod_next     = prod_reg;
        ram_we        = 1'b0;
        ram_waddr     = cnt_m2[AW-1:0];
        ram_wdata     = rd_top;
        fin           = 1'b0;
        fin_status    = sme_pkg::ST_OK;
        fin_printed   = 1'b0;
        fin_pval      = '0;
        div_req.start = 1'b0;
        div_req.num   = rd_sec;
        div_req.den   = rd_top;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (halted_reg) begin
                    fin        = 1'b1;
                    fin_status = sme_pkg::ST_HALTED;
                end else begin
                    case (sme_pkg::op_t'(act_reg))
                        sme_pkg::OP_PUSH: begin
                            fin = 1'b1;
                            if (n_full) begin
                                fin_status = sme_pkg::ST_OVERFLOW;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = imm_reg;
                                count_next = cnt_p1;
                            end
                        end
                        sme_pkg::OP_POP: begin
                            fin = 1'b1;
                            if (n_empty) begin
                                fin_status = sme_pkg::ST_UNDERFLOW;
                            end else begin
                                count_next = cnt_m1;
                            end
                        end
                        sme_pkg::OP_DUP: begin
                            fin = 1'b1;
                            if (n_empty) begin
                                fin_status = sme_pkg::ST_UNDERFLOW;
                            end else if (n_full) begin
                                fin_status = sme_pkg::ST_OVERFLOW;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = rd_top;
                                count_next = cnt_p1;
                            end
                        end
                        sme_pkg::OP_SWAP: begin
                            if (n_lt2) begin
                                fin        = 1'b1;
                                fin_status = sme_pkg::ST_UNDERFLOW;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = cnt_m1[AW-1:0];
                                ram_wdata  = rd_sec;
                                opa_next   = rd_top;
                                state_next = S_SWAP2;
                            end
                        end
                        sme_pkg::OP_ADD, sme_pkg::OP_SUB: begin
                            fin = 1'b1;
                            if (n_lt2) begin
                                fin_status = sme_pkg::ST_UNDERFLOW;
                            end else begin
                                ram_we     = 1'b1;
                                ram_waddr  = cnt_m2[AW-1:0];
                                ram_wdata  = (act_reg == sme_pkg::OP_ADD) ?
                                             rd_sec + rd_top : rd_sec - rd_top;
                                count_next = cnt_m1;
                            end
                        end
                        sme_pkg::OP_MUL: begin
                            if (n_lt2) begin
                                fin        = 1'b1;
                                fin_status = sme_pkg::ST_UNDERFLOW;
                            end else begin
                                prod_next  = full_prod;
                                state_next = S_MULW;
                            end
                        end
                        sme_pkg::OP_DIV: begin
                            if (n_lt2) begin
                                fin        = 1'b1;
                                fin_status = sme_pkg::ST_UNDERFLOW;
                            end else if (rd_top == '0) begin
                                fin        = 1'b1;
                                fin_status = sme_pkg::ST_DIVZERO;
                            end else begin
                                div_req.start = 1'b1;
                                state_next    = S_DIVW;
                            end
                        end
                        sme_pkg::OP_PRINT: begin
                            fin = 1'b1;
                            if (n_empty) begin
                                fin_status = sme_pkg::ST_UNDERFLOW;
                            end else begin
                                fin_printed = 1'b1;
                                fin_pval    = rd_top;
                                count_next  = cnt_m1;
                            end
                        end
                        default: begin
                            fin        = 1'b1;
                            fin_status = sme_pkg::ST_UNKNOWN;
                        end
                    endcase
                    if (fin && fin_status != sme_pkg::ST_OK) begin
                        halted_next = 1'b1;
                    end
                end
            end
            S_SWAP2: begin
                fin       = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = cnt_m2[AW-1:0];
                ram_wdata = opa_reg;
            end
            S_MULW: begin
                fin        = 1'b1;
                ram_we     = 1'b1;
                ram_waddr  = cnt_m2[AW-1:0];
                ram_wdata  = prod_reg;
                count_next = cnt_m1;
            end
            S_DIVW: begin
                if (div_rsp.done) begin
                    fin        = 1'b1;
                    ram_we     = 1'b1;
                    ram_waddr  = cnt_m2[AW-1:0];
                    ram_wdata  = div_rsp.quotient;
                    count_next = cnt_m1;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (fin) begin
            state_next = out_free ? S_IDLE : S_HOLD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            halted_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            halted_reg <= halted_next;
            if (fin && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (state_reg == S_HOLD && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        opa_reg  <= opa_next;
        prod_reg <= prod_next;
        if (accept) begin
            act_reg <= s_tdata[3:0];
            imm_reg <= s_tdata[35:4];
        end
        if (fin && out_free) begin
            m_status_reg  <= fin_status;
            m_printed_reg <= fin_printed;
            m_pval_reg    <= fin_pval;
            m_depth_reg   <= count_next;
        end else if (state_reg == S_HOLD && out_free) begin
            m_status_reg  <= hold_status_reg;
            m_printed_reg <= hold_printed_reg;
            m_pval_reg    <= hold_pval_reg;
            m_depth_reg   <= hold_depth_reg;
        end
        if (fin && !out_free) begin
            hold_status_reg  <= fin_status;
            hold_printed_reg <= fin_printed;
            hold_pval_reg    <= fin_pval;
            hold_depth_reg   <= count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_depth_reg, m_pval_reg, m_printed_reg, m_status_reg};

    // Once halted, only reset brings the machine back.
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halted condition cleared without reset");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(sme_pkg::STACK_DEPTH))
        else $error("stack count beyond stack depth");

    // The stack RAM is only written while an instruction is being executed.
    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg != S_IDLE && state_reg != S_HOLD))
        else $error("stack write outside execution");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == S_DIVW)
        else $error("divider finished while no divide is pending");

    // A halted machine must leave the stack depth untouched.
    a_halt_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (halted_reg && state_reg == S_EXEC) |=> count_reg == $past(count_reg))
        else $error("stack depth changed while halted");

endmodule
